/* hdl/isim_pkg.sv */
// ----------------------------------------------------------------------------
// isim_pkg
// Shared constants and types for the interval set insert/merge block.
// ----------------------------------------------------------------------------
package isim_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_CMP2,
    ST_FINISH,
    ST_ERD,
    ST_EOUT
  } isim_state_t;

endpackage

/* hdl/interval_set_insert_merge.sv */
// ----------------------------------------------------------------------------
// interval_set_insert_merge
// Sorted set of disjoint closed intervals; each insert merges overlapping
// entries and the set (unchanged if the insert is dropped) is streamed out in ascending order.
// ----------------------------------------------------------------------------
// channel | signals                                  | direction
// --------+------------------------------------------+----------
// in      | in_valid, in_stall, new_start, new_end   | sink
// out     | out_valid, out_stall, out_start, out_end,| source
//         | last_of_set, insert_dropped              |
//
// The merge pass reads each stored entry (ST_RD) and compares it (ST_CMP),
// with an extra write state (ST_CMP2) for the entry in front of which the new
// interval lands; each emitted entry is read (ST_ERD) and offered (ST_EOUT),
// one at a time through the single read port of the two-bank interval memory.
// Reset clears the control state and the entry count; the memory holds no reset value.
// out_stall holds the current output transaction; in_stall is high until
// the last interval of the set has been taken.
// ----------------------------------------------------------------------------
module interval_set_insert_merge
  import isim_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] new_start,
  input  logic signed [DATA_W-1:0] new_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_start,
  output logic signed [DATA_W-1:0] out_end,
  output logic                     last_of_set,
  output logic                     insert_dropped
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int NW    = $clog2(CAPACITY + 2);
  localparam int DEPTH = 2 ** (AW + 1);

  // two banks: the active one holds the set, the other takes the merged list
  logic signed [DATA_W-1:0] mem_s [DEPTH];
  logic signed [DATA_W-1:0] mem_e [DEPTH];

  isim_state_t state, state_next;
  logic              bank, bank_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     idx, idx_next;
  logic [NW-1:0]     n, n_next;
  logic              placed, placed_next;
  logic              dropped, dropped_next;
  logic signed [DATA_W-1:0] s, s_next, e, e_next;
  logic signed [DATA_W-1:0] rd_s, rd_e;

  logic [AW:0]              raddr, waddr;
  logic                     we;
  logic signed [DATA_W-1:0] wd_s, wd_e;
  logic [NW-1:0]            n_final;
  logic                     idx_last;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_s[waddr] <= wd_s;
      mem_e[waddr] <= wd_e;
    end
    rd_s <= mem_s[raddr];
    rd_e <= mem_e[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bank    <= 1'b0;
      count   <= '0;
      idx     <= '0;
      n       <= '0;
      placed  <= 1'b0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      bank    <= bank_next;
      count   <= count_next;
      idx     <= idx_next;
      n       <= n_next;
      placed  <= placed_next;
      dropped <= dropped_next;
    end
    s <= s_next;
    e <= e_next;
  end

  assign idx_last = ({1'b0, idx} + 1'b1) == {1'b0, count};
  assign n_final  = n + {{(NW-1){1'b0}}, !placed};

  always_comb begin
    state_next   = state;
    bank_next    = bank;
    count_next   = count;
    idx_next     = idx;
    n_next       = n;
    placed_next  = placed;
    dropped_next = dropped;
    s_next       = s;
    e_next       = e;
    raddr        = {bank, idx[AW-1:0]};
    waddr        = {!bank, n[AW-1:0]};
    we           = 1'b0;
    wd_s         = rd_s;
    wd_e         = rd_e;
    in_stall     = 1'b1;
    out_valid    = 1'b0;

    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          // swapped end points cover the same points
          if (new_end < new_start) begin
            s_next = new_end;
            e_next = new_start;
          end else begin
            s_next = new_start;
            e_next = new_end;
          end
          idx_next     = '0;
          n_next       = '0;
          placed_next  = 1'b0;
          dropped_next = 1'b0;
          state_next   = (count == '0) ? ST_FINISH : ST_RD;
        end
      end
      ST_RD: state_next = ST_CMP;
      ST_CMP: begin
        if (rd_e < s) begin
          we     = (n < NW'(CAPACITY));
          n_next = n + 1'b1;
        end else if (rd_s > e) begin
          we     = (n < NW'(CAPACITY));
          n_next = n + 1'b1;
          if (!placed) begin
            wd_s        = s;
            wd_e        = e;
            placed_next = 1'b1;
          end
        end else begin
          if (rd_s < s) s_next = rd_s;
          if (rd_e > e) e_next = rd_e;
        end
        if ((rd_s > e) && (rd_e >= s) && !placed) begin
          state_next = ST_CMP2;  // stored entry still to be written
        end else begin
          idx_next   = idx + 1'b1;
          state_next = idx_last ? ST_FINISH : ST_RD;
        end
      end
      ST_CMP2: begin
        we         = (n < NW'(CAPACITY));
        n_next     = n + 1'b1;
        idx_next   = idx + 1'b1;
        state_next = idx_last ? ST_FINISH : ST_RD;
      end
      ST_FINISH: begin
        if (!placed) begin
          wd_s = s;
          wd_e = e;
          we   = (n < NW'(CAPACITY));
        end
        if (n_final > NW'(CAPACITY)) begin
          dropped_next = 1'b1;
        end else begin
          bank_next  = !bank;
          count_next = n_final[CW-1:0];
        end
        idx_next   = '0;
        state_next = ST_ERD;
      end
      ST_ERD: state_next = ST_EOUT;
      ST_EOUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (idx_last) begin
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ST_ERD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_start      = rd_s;
  assign out_end        = rd_e;
  assign last_of_set    = idx_last;
  assign insert_dropped = dropped;

endmodule

/* hdl/isim_checker.sv */
// ----------------------------------------------------------------------------
// isim_checker
// Port-level checks on the interval set block, bound to its top level.
// ----------------------------------------------------------------------------
module isim_checker
  import isim_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic signed [DATA_W-1:0] new_start,
  input logic signed [DATA_W-1:0] new_end,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_start,
  input logic signed [DATA_W-1:0] out_end,
  input logic                     last_of_set,
  input logic                     insert_dropped
);

  // no new insert while a set is being emitted
  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while output is valid");

  // an accepted insert always takes a merge or finish step before any output
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("no merge pass after insert");

  // the set ends with the last-marked transaction
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_of_set) |=> !out_valid)
    else $error("output continued past last interval");

  // drop flag is the same on every transaction of one set
  a_drop_const: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_set) |=> !out_valid ##1
      (out_valid && (insert_dropped == $past(insert_dropped, 2))))
    else $error("drop flag changed within a set");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_start) && $stable(out_end)))
    else $error("stalled output changed");

endmodule

bind interval_set_insert_merge isim_checker u_isim_checker (.*);

/* verif/interval_set_insert_merge_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_insert_merge_tb
// Self-checking bench for the interval set insert/merge block. A table of
// hand-picked inserts (extremes, swapped end points, shared end points,
// adjacent-but-disjoint spans) runs first. It is followed by random
// fill-and-collapse sequences, noise around fixed anchors and hits on
// stored entries. Every emitted entry is checked against a behavioral
// model of the set, under several idle/stall mixes and one long output
// hold.
// ----------------------------------------------------------------------------
module interval_set_insert_merge_tb;
  import isim_pkg::*;

  localparam int     SET_CAP     = CAPACITY_DEF;
  localparam int     CLK_PERIOD  = 10;
  localparam int     RAND_ITEMS  = 400;
  localparam int     HOLD_CYCLES = 600;
  localparam int     DIR_ROWS    = 20;
  localparam longint W_MIN       = -64'sd2147483648;
  localparam longint W_MAX       = 64'sd2147483647;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct {
    word_t lo;
    word_t hi;
    logic  last;
    logic  dropped;
  } set_entry_t;

  typedef struct {
    longint s;
    longint e;
    bit     typed;
    longint t_lo;
    longint t_hi;
  } dir_row_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  word_t new_start;
  word_t new_end;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t out_start;
  word_t out_end;
  logic  last_of_set;
  logic  insert_dropped;

  // model of the stored set
  word_t set_lo [SET_CAP];
  word_t set_hi [SET_CAP];
  int    set_count;

  set_entry_t pending_entries [$];

  int in_idle_pct   = 9;
  int out_stall_pct = 9;
  bit hold_armed    = 1'b0;
  bit hold_taken    = 1'b0;
  int hold_left     = 0;

  int items_sent;
  int rand_sent;
  int entries_checked;
  int mismatch_count;
  int drop_count;
  int peak_count;

  // typed rows expect a single entry, not dropped
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{W_MIN,       W_MIN,       1'b1, W_MIN, W_MIN},
    '{W_MIN + 1,   W_MIN,       1'b1, W_MIN, W_MIN + 1},
    '{W_MAX,       W_MAX,       1'b0, 0, 0},
    '{W_MAX,       W_MAX - 1,   1'b0, 0, 0},
    '{5,           5,           1'b0, 0, 0},
    '{10,          3,           1'b0, 0, 0},
    '{11,          20,          1'b0, 0, 0},
    '{20,          25,          1'b0, 0, 0},
    '{-1,          0,           1'b0, 0, 0},
    '{0,           2,           1'b0, 0, 0},
    '{26,          30,          1'b0, 0, 0},
    '{-5,          40,          1'b0, 0, 0},
    '{95,          95,          1'b0, 0, 0},
    '{100,         90,          1'b0, 0, 0},
    '{-70000,      -1000,       1'b0, 0, 0},
    '{-1000,       -6,          1'b0, 0, 0},
    '{W_MAX - 100, W_MAX - 2,   1'b0, 0, 0},
    '{W_MAX - 2,   W_MAX - 1,   1'b0, 0, 0},
    '{41,          89,          1'b0, 0, 0},
    '{40,          90,          1'b0, 0, 0}
  };

  interval_set_insert_merge u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .new_start      (new_start),
    .new_end        (new_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_start      (out_start),
    .out_end        (out_end),
    .last_of_set    (last_of_set),
    .insert_dropped (insert_dropped)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic word_t clamp_word(longint v);
    if (v > W_MAX) return 32'sh7FFF_FFFF;
    if (v < W_MIN) return 32'sh8000_0000;
    return word_t'(v);
  endfunction

  // Merge one interval into the model set and, unless quiet, queue the emitted set.
  function automatic void predict_insert(word_t s_in, word_t e_in, bit quiet);
    word_t lo;
    word_t hi;
    word_t a;
    word_t b;
    word_t nlo [SET_CAP+1];
    word_t nhi [SET_CAP+1];
    int    n;
    bit    placed;
    bit    dropped;
    lo     = (e_in < s_in) ? e_in : s_in;
    hi     = (e_in < s_in) ? s_in : e_in;
    n      = 0;
    placed = 1'b0;
    for (int i = 0; i < set_count; i++) begin
      a = set_lo[i];
      b = set_hi[i];
      if (b < lo) begin
        nlo[n] = a;
        nhi[n] = b;
        n++;
      end else if (a > hi) begin
        if (!placed) begin
          nlo[n] = lo;
          nhi[n] = hi;
          n++;
          placed = 1'b1;
        end
        nlo[n] = a;
        nhi[n] = b;
        n++;
      end else begin
        // overlap, shared end point included
        if (a < lo) lo = a;
        if (b > hi) hi = b;
      end
    end
    if (!placed) begin
      nlo[n] = lo;
      nhi[n] = hi;
      n++;
    end
    dropped = (n > SET_CAP);
    if (dropped) begin
      drop_count++;
    end else begin
      for (int i = 0; i < n; i++) begin
        set_lo[i] = nlo[i];
        set_hi[i] = nhi[i];
      end
      set_count = n;
    end
    if (set_count > peak_count) peak_count = set_count;
    if (!quiet) begin
      for (int i = 0; i < set_count; i++) begin
        pending_entries.push_back('{set_lo[i], set_hi[i], i == set_count - 1, dropped});
      end
    end
  endfunction

  // Offer one transaction; payload held until taken. Starts and ends at a falling edge.
  task automatic send_interval(word_t s, word_t e, bit typed, word_t t_lo, word_t t_hi);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    new_start <= s;
    new_end   <= e;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_insert(s, e, typed);
    if (typed) pending_entries.push_back('{t_lo, t_hi, 1'b1, 1'b0});
    items_sent++;
    @(negedge clk);
  endtask

  task automatic offer_span(longint lo, longint hi);
    if ($urandom_range(3) == 0) begin
      send_interval(clamp_word(hi), clamp_word(lo), 1'b0, '0, '0);
    end else begin
      send_interval(clamp_word(lo), clamp_word(hi), 1'b0, '0, '0);
    end
    rand_sent++;
  endtask

  // output side: random stall, plus one long hold to back up the input
  always @(negedge clk) begin
    if (hold_armed && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin : entry_check
    set_entry_t want;
    if (!rst && out_valid && !out_stall) begin
      entries_checked++;
      if (pending_entries.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected set entry [%0d, %0d] last %0b dropped %0b",
                 $time, out_start, out_end, last_of_set, insert_dropped);
      end else begin
        want = pending_entries.pop_front();
        if (out_start !== want.lo || out_end !== want.hi ||
            last_of_set !== want.last || insert_dropped !== want.dropped) begin
          mismatch_count++;
          $display("%0t: expected [%0d, %0d] last %0b dropped %0b, got [%0d, %0d] last %0b dropped %0b",
                   $time, want.lo, want.hi, want.last, want.dropped,
                   out_start, out_end, last_of_set, insert_dropped);
        end
      end
    end
  end

  initial begin
    int     kind;
    int     i;
    int     j;
    longint stride;
    longint base;
    longint lo;
    longint w;
    longint spine_lo;
    longint spine_hi;
    longint noise_anchor [6];
    rst       = 1'b1;
    in_valid  = 1'b0;
    new_start = '0;
    new_end   = '0;
    set_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      send_interval(clamp_word(dir_rows[r].s), clamp_word(dir_rows[r].e), dir_rows[r].typed,
                    clamp_word(dir_rows[r].t_lo), clamp_word(dir_rows[r].t_hi));
    end

    // Covered range only grows, so random work stays in narrow arenas laid
    // out after one growing spine; each arena is folded back into it.
    foreach (noise_anchor[k]) noise_anchor[k] = longint'(int'($urandom()));
    spine_lo   = longint'($urandom_range(32'h7FFF_FFFF)) - 64'sd1073741824;
    spine_hi   = spine_lo;
    hold_armed = 1'b1;
    while (rand_sent < RAND_ITEMS) begin
      case (rand_sent * 4 / RAND_ITEMS)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 50;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 50;
        end
        default: begin
          in_idle_pct   = 9;
          out_stall_pct = 9;
        end
      endcase
      kind = $urandom_range(9);
      if (kind < 7) begin
        // fill an arena, at times past capacity, then collapse it into the spine
        stride = ($urandom_range(3) == 0) ? $urandom_range(65536, 2) : $urandom_range(64, 2);
        base   = spine_hi + stride * $urandom_range(4, 1);
        repeat ($urandom_range(45, 8)) begin
          lo = base + stride * $urandom_range(63);
          w  = ($urandom_range(7) == 0) ? stride * $urandom_range(3, 1)
                                        : $urandom_range(stride - 1);
          offer_span(lo, lo + w);
        end
        spine_hi = base + 67 * stride;
        offer_span(spine_lo, spine_hi);
      end else if (kind < 9) begin
        repeat ($urandom_range(4, 1)) begin
          lo = noise_anchor[$urandom_range(5)] + $urandom_range(128) - 64;
          offer_span(lo, lo + $urandom_range(8));
        end
      end else begin
        // land on a stored entry, sometimes bridging to a close neighbor
        i = $urandom_range(set_count - 1);
        j = i;
        if (i + 1 < set_count && $urandom_range(1) == 1 &&
            longint'(set_lo[i+1]) - longint'(set_hi[i]) < 64'sd16777216) j = i + 1;
        offer_span(longint'(set_lo[i]) + $urandom_range(4) - 2,
                   longint'(set_hi[j]) + $urandom_range(4) - 2);
      end
    end
    in_valid <= 1'b0;

    while (pending_entries.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Ran %0d inserts (%0d from the table, %0d random), %0d set entries checked.",
             items_sent, items_sent - rand_sent, rand_sent, entries_checked);
    $display("%0d inserts hit a full set and were dropped; largest set held %0d entries.",
             drop_count, peak_count);
    if (mismatch_count == 0) begin
      $display("interval_set_insert_merge: match");
    end else begin
      $display("interval_set_insert_merge: mismatch");
    end
    $finish;
  end

  // worst case is well under 2 ms; allow ten times that
  initial begin
    #20_000_000;
    $display("interval_set_insert_merge: mismatch");
    $finish;
  end

endmodule

/* sim.f */
hdl/isim_pkg.sv
hdl/interval_set_insert_merge.sv
hdl/isim_checker.sv
verif/interval_set_insert_merge_tb.sv
